/* rtl/efwjs_pkg.sv */
`default_nettype none

package efwjs_pkg;

  localparam int MAX_WORKERS_DEF = 16;
  localparam int TIME_W          = 64;
  localparam int DUR_W           = 32;
  localparam int CFG_W           = 5;
  localparam int WID_W           = 4;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_we;
    logic scan_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic in_restart;
    logic clr_last;
    logic scan_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/earliest_free_worker_job_scheduler.sv */
// Earliest-free-worker job scheduler. Each accepted word (a job duration and a
// restart flag) is assigned to the active worker with the smallest next-free
// time, lowest worker number on ties; the result word gives that worker and
// the job's start time, and the worker's free time then advances by the
// duration, saturating at all ones. Free times live in a RAM that one shared
// comparator scans one entry per cycle, over the N active workers (cfg value,
// 0 read as 1, capped at MAX_WORKERS). A word with restart set first zeroes
// the whole RAM; the same clearing pass runs after reset, during which no
// input word is taken. A finished result waits in an output register while
// the next job is already being accepted. cfg_ready is always high; write
// active_workers only while the block is idle.
`default_nettype none

module earliest_free_worker_job_scheduler import efwjs_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_active_workers,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [DUR_W-1:0]  in_job_duration,
  input  wire logic              in_restart,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WID_W-1:0]  out_worker_index,
  output logic      [TIME_W-1:0] out_start_time
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  efwjs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  efwjs_dp #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_active_workers (cfg_active_workers),
    .in_job_duration    (in_job_duration),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_worker_index   (out_worker_index),
    .out_start_time     (out_start_time),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

`default_nettype wire

/* rtl/efwjs_ram.sv */
`default_nettype none

module efwjs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/efwjs_ctrl.sv */
`default_nettype none

module efwjs_ctrl import efwjs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   job_r, job_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      job_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = job_r ? ST_SCAN : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_restart ? ST_CLEAR : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    job_nxt  = job_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          job_nxt = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_COMMIT: begin
        cmd.commit = !sts.out_busy;
        if (!sts.out_busy) begin
          job_nxt = 1'b0;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_scan_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> job_r)
    else $error("scan running without a job");

  a_accept_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_SCAN || state_r == ST_CLEAR))
    else $error("accepted word did not start work");

  a_commit_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (state_r == ST_IDLE && !job_r))
    else $error("commit did not close the job");

endmodule

`default_nettype wire

/* rtl/efwjs_dp.sv */
`default_nettype none

module efwjs_dp import efwjs_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire logic [CFG_W-1:0]  cfg_active_workers,
  input  wire logic [DUR_W-1:0]  in_job_duration,
  input  wire logic              in_restart,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WID_W-1:0]  out_worker_index,
  output logic      [TIME_W-1:0] out_start_time,
  input  wire cmd_t              cmd,
  output sts_t                   sts
);

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]  active_r;
  logic [DUR_W-1:0]  dur_r;
  logic [IDX_W-1:0]  addr_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [TIME_W-1:0] best_val_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              out_valid_r;
  logic [WID_W-1:0]  out_worker_r;
  logic [TIME_W-1:0] out_time_r;

  logic [CMP_W-1:0]  act_ext;
  logic [CMP_W-1:0]  used_n;
  logic [CMP_W-1:0]  used_m1;
  logic [IDX_W-1:0]  last_idx;
  logic              step;
  logic              step_last;
  logic [TIME_W:0]   sum_w;
  logic [TIME_W-1:0] new_time;
  logic [IDX_W+WID_W-1:0] idx_ext;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [TIME_W-1:0] ram_wdata;
  logic [TIME_W-1:0] ram_rdata;

  always_comb begin
    act_ext = CMP_W'(active_r);
    if (act_ext == '0) begin
      used_n = CMP_W'(1);
    end else if (act_ext > CMP_W'(MAX_WORKERS)) begin
      used_n = CMP_W'(MAX_WORKERS);
    end else begin
      used_n = act_ext;
    end
    used_m1  = used_n - CMP_W'(1);
    last_idx = used_m1[IDX_W-1:0];
  end

  assign sts.in_restart = in_restart;
  assign sts.clr_last   = (addr_r == IDX_W'(MAX_WORKERS - 1));
  assign sts.scan_last  = (addr_r == last_idx);
  assign sts.out_busy   = out_valid_r && out_stall;

  assign step      = cmd.clr_we || cmd.scan_rd;
  assign step_last = cmd.clr_we ? sts.clr_last : sts.scan_last;

  assign sum_w    = {1'b0, best_val_r} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur_r};
  assign new_time = sum_w[TIME_W] ? {TIME_W{1'b1}} : sum_w[TIME_W-1:0];
  assign idx_ext  = {{WID_W{1'b0}}, best_idx_r};

  assign ram_we    = cmd.clr_we || cmd.commit;
  assign ram_waddr = cmd.clr_we ? addr_r : best_idx_r;
  assign ram_wdata = cmd.clr_we ? '0 : new_time;

  efwjs_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_WORKERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACTIVE_RESET;
      addr_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        active_r <= cfg_active_workers;
      end
      if (cmd.accept) begin
        addr_r <= '0;
      end else if (step) begin
        addr_r <= step_last ? '0 : addr_r + IDX_W'(1);
      end
      cmp_vld_r <= cmd.scan_rd;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dur_r <= in_job_duration;
    end
    cmp_idx_r <= addr_r;
    if (cmp_vld_r && (cmp_idx_r == '0 || ram_rdata < best_val_r)) begin
      best_val_r <= ram_rdata;
      best_idx_r <= cmp_idx_r;
    end
    if (cmd.commit) begin
      out_worker_r <= idx_ext[WID_W-1:0];
      out_time_r   <= best_val_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_worker_index = out_worker_r;
  assign out_start_time   = out_time_r;

  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("commit into a full output register");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed word not presented");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (CMP_W'(cmp_idx_r) <= used_m1))
    else $error("compare outside active workers");

endmodule

`default_nettype wire
